>>> hdl/grex_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grex_pkg - glyph run extents shared definitions
// Field widths and the default coordinate width used by the accumulator.
// ----------------------------------------------------------------------------
package grex_pkg;

  // Width of every coordinate field on the ports.
  localparam int FIELD_BITS = 32;

  // Default width of the internal coordinate arithmetic.
  localparam int COORD_BITS_DEF = 32;

  // Widest coordinate supported; used as an intermediate for extension.
  localparam int EXT_BITS = 64;

endpackage

>>> hdl/glyph_run_extents_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glyph_run_extents_accumulator_top - glyph run extents accumulator
// Accumulates pen position, ink bounding box and logical rectangle over a
// run of glyphs and emits both rectangles on the last glyph of the run.
// ----------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid / in_stall    | first_glyph, last_glyph, ink_*, logic_*,
//          |                        | advance, offset_x, offset_y
//  out     | out_valid / out_stall  | run_ink_*, run_logical_*
//
//  One glyph per cycle while in_stall is low. A request is captured in the
//  input register; as it leaves that register the running state updates and,
//  for a last glyph, the result register loads. Synchronous reset clears both
//  valid flags and all running state to zero. A held result stalls only a last
//  glyph waiting behind it, and the glyphs behind that; other glyphs keep flowing.
// ----------------------------------------------------------------------------
module glyph_run_extents_accumulator_top
  import grex_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         first_glyph,
  input  logic                         last_glyph,
  input  logic signed [FIELD_BITS-1:0] ink_left,
  input  logic signed [FIELD_BITS-1:0] ink_top,
  input  logic signed [FIELD_BITS-1:0] ink_span_x,
  input  logic signed [FIELD_BITS-1:0] ink_span_y,
  input  logic signed [FIELD_BITS-1:0] logic_top,
  input  logic signed [FIELD_BITS-1:0] logic_span_y,
  input  logic signed [FIELD_BITS-1:0] advance,
  input  logic signed [FIELD_BITS-1:0] offset_x,
  input  logic signed [FIELD_BITS-1:0] offset_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [FIELD_BITS-1:0] run_ink_x,
  output logic signed [FIELD_BITS-1:0] run_ink_y,
  output logic signed [FIELD_BITS-1:0] run_ink_width,
  output logic signed [FIELD_BITS-1:0] run_ink_height,
  output logic signed [FIELD_BITS-1:0] run_logical_y,
  output logic signed [FIELD_BITS-1:0] run_logical_width,
  output logic signed [FIELD_BITS-1:0] run_logical_height
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // Port field to coordinate: sign extend, then wrap to COORD_BITS.
  function automatic coord_t to_coord(input logic signed [FIELD_BITS-1:0] v);
    logic signed [EXT_BITS-1:0] e;
    e = EXT_BITS'(v);
    return e[COORD_BITS-1:0];
  endfunction

  // Coordinate to port field: zero extend, then keep the low field bits.
  function automatic logic signed [FIELD_BITS-1:0] to_field(input coord_t v);
    logic [EXT_BITS-1:0] e;
    e = EXT_BITS'(unsigned'(v));
    return e[FIELD_BITS-1:0];
  endfunction

  // ---------------- input register ----------------
  logic   s1_valid;
  logic   s1_first;
  logic   s1_last;
  logic   s1_has_ink;
  coord_t s1_gxo;      // ink_left + offset_x
  coord_t s1_gxo_end;  // ink_left + offset_x + ink_span_x
  coord_t s1_top;
  coord_t s1_top_end;
  coord_t s1_gw;
  coord_t s1_gh;
  coord_t s1_ly;
  coord_t s1_ly_end;
  coord_t s1_lh;
  coord_t s1_adv;

  logic   in_accept;
  logic   s1_adv_ok;
  logic   out_free;
  logic   out_load;
  coord_t c_gxo;
  coord_t c_top;
  coord_t c_gw;
  coord_t c_gh;
  coord_t c_ly;

  assign out_free  = !out_valid || !out_stall;
  assign s1_adv_ok = s1_valid && (!s1_last || out_free);
  assign in_stall  = s1_valid && !s1_adv_ok;
  assign in_accept = in_valid && !in_stall;
  assign out_load  = s1_adv_ok && s1_last;

  always_comb begin
    c_gxo = to_coord(ink_left) + to_coord(offset_x);
    c_top = to_coord(ink_top) + to_coord(offset_y);
    c_gw  = to_coord(ink_span_x);
    c_gh  = to_coord(ink_span_y);
    c_ly  = to_coord(logic_top);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_accept || (s1_valid && !s1_adv_ok);
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_first   <= first_glyph;
      s1_last    <= last_glyph;
      s1_has_ink <= (c_gw != '0) && (c_gh != '0);
      s1_gxo     <= c_gxo;
      s1_gxo_end <= c_gxo + c_gw;
      s1_top     <= c_top;
      s1_top_end <= c_top + c_gh;
      s1_gw      <= c_gw;
      s1_gh      <= c_gh;
      s1_ly      <= c_ly;
      s1_ly_end  <= c_ly + to_coord(logic_span_y);
      s1_lh      <= to_coord(logic_span_y);
      s1_adv     <= to_coord(advance);
    end
  end

  // ---------------- running state ----------------
  coord_t pen_position;
  coord_t acc_ink_x;
  coord_t acc_ink_y;
  coord_t acc_ink_width;
  coord_t acc_ink_height;
  coord_t acc_logical_y;
  coord_t acc_logical_width;
  coord_t acc_logical_height;

  coord_t pen_position_next;
  coord_t acc_ink_x_next;
  coord_t acc_ink_y_next;
  coord_t acc_ink_width_next;
  coord_t acc_ink_height_next;
  coord_t acc_logical_y_next;
  coord_t acc_logical_width_next;
  coord_t acc_logical_height_next;

  // state as seen by this glyph: a first glyph starts from zero
  coord_t pen_e;
  coord_t ink_x_e;
  coord_t ink_y_e;
  coord_t ink_w_e;
  coord_t ink_h_e;
  coord_t lw_e;
  coord_t left;
  coord_t right;
  coord_t ux_pos;
  coord_t ux_len;
  coord_t uy_pos;
  coord_t uy_len;
  coord_t ul_pos;
  coord_t ul_len;

  always_comb begin
    pen_e   = s1_first ? '0 : pen_position;
    ink_x_e = s1_first ? '0 : acc_ink_x;
    ink_y_e = s1_first ? '0 : acc_ink_y;
    ink_w_e = s1_first ? '0 : acc_ink_width;
    ink_h_e = s1_first ? '0 : acc_ink_height;
    lw_e    = s1_first ? '0 : acc_logical_width;
    left    = pen_e + s1_gxo;
    right   = pen_e + s1_gxo_end;
  end

  grex_union #(.COORD_BITS(COORD_BITS)) u_ink_x (
    .a_pos (ink_x_e),
    .a_len (ink_w_e),
    .b_pos (left),
    .b_end (right),
    .u_pos (ux_pos),
    .u_len (ux_len)
  );

  grex_union #(.COORD_BITS(COORD_BITS)) u_ink_y (
    .a_pos (ink_y_e),
    .a_len (ink_h_e),
    .b_pos (s1_top),
    .b_end (s1_top_end),
    .u_pos (uy_pos),
    .u_len (uy_len)
  );

  grex_union #(.COORD_BITS(COORD_BITS)) u_logical_y (
    .a_pos (acc_logical_y),
    .a_len (acc_logical_height),
    .b_pos (s1_ly),
    .b_end (s1_ly_end),
    .u_pos (ul_pos),
    .u_len (ul_len)
  );

  always_comb begin
    acc_ink_x_next      = ink_x_e;
    acc_ink_y_next      = ink_y_e;
    acc_ink_width_next  = ink_w_e;
    acc_ink_height_next = ink_h_e;
    if (s1_has_ink) begin
      // an empty box (zero width or height) is replaced, not extended
      if (ink_w_e == '0 || ink_h_e == '0) begin
        acc_ink_x_next      = left;
        acc_ink_y_next      = s1_top;
        acc_ink_width_next  = s1_gw;
        acc_ink_height_next = s1_gh;
      end else begin
        acc_ink_x_next      = ux_pos;
        acc_ink_y_next      = uy_pos;
        acc_ink_width_next  = ux_len;
        acc_ink_height_next = uy_len;
      end
    end
    acc_logical_width_next  = lw_e + s1_adv;
    acc_logical_y_next      = s1_first ? s1_ly : ul_pos;
    acc_logical_height_next = s1_first ? s1_lh : ul_len;
    pen_position_next       = pen_e + s1_adv;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_position       <= '0;
      acc_ink_x          <= '0;
      acc_ink_y          <= '0;
      acc_ink_width      <= '0;
      acc_ink_height     <= '0;
      acc_logical_y      <= '0;
      acc_logical_width  <= '0;
      acc_logical_height <= '0;
    end else if (s1_adv_ok) begin
      pen_position       <= pen_position_next;
      acc_ink_x          <= acc_ink_x_next;
      acc_ink_y          <= acc_ink_y_next;
      acc_ink_width      <= acc_ink_width_next;
      acc_ink_height     <= acc_ink_height_next;
      acc_logical_y      <= acc_logical_y_next;
      acc_logical_width  <= acc_logical_width_next;
      acc_logical_height <= acc_logical_height_next;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      run_ink_x          <= to_field(acc_ink_x_next);
      run_ink_y          <= to_field(acc_ink_y_next);
      run_ink_width      <= to_field(acc_ink_width_next);
      run_ink_height     <= to_field(acc_ink_height_next);
      run_logical_y      <= to_field(acc_logical_y_next);
      run_logical_width  <= to_field(acc_logical_width_next);
      run_logical_height <= to_field(acc_logical_height_next);
    end
  end

`ifndef SYNTHESIS
  // back pressure only comes from a pending request
  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("in_stall raised with empty input register");

  // a held result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !out_load)
    else $error("result register overwritten while stalled");

  // a new result only follows a last glyph leaving the input register
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_adv_ok && s1_last))
    else $error("result appeared without a last glyph");

  // state only moves when a glyph is consumed
  a_pen_hold: assert property (@(posedge clk) disable iff (rst)
    (!s1_valid) |=> $stable(pen_position) || $past(rst))
    else $error("pen position changed with no glyph");
`endif

endmodule

>>> hdl/grex_union.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grex_union - one-axis span union
// Merges a held span (pos, len) with a new span (pos, end) by signed
// min/max; all arithmetic wraps at COORD_BITS.
// ----------------------------------------------------------------------------
module grex_union
  import grex_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] a_pos,
  input  logic signed [COORD_BITS-1:0] a_len,
  input  logic signed [COORD_BITS-1:0] b_pos,
  input  logic signed [COORD_BITS-1:0] b_end,
  output logic signed [COORD_BITS-1:0] u_pos,
  output logic signed [COORD_BITS-1:0] u_len
);

  logic signed [COORD_BITS-1:0] a_end;
  logic signed [COORD_BITS-1:0] u_end;

  always_comb begin
    a_end = a_pos + a_len;
    u_pos = (b_pos < a_pos) ? b_pos : a_pos;
    u_end = (a_end < b_end) ? b_end : a_end;
    u_len = u_end - u_pos;
  end

endmodule

>>> tb/sv/tb_glyph_run_extents_accumulator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_glyph_run_extents_accumulator_top - glyph run extents testbench
// Streams glyph runs into the accumulator under random input gaps and output
// stalls, predicts the ink box and logical rectangle of every run, and checks
// each result in order against the prediction.
// ----------------------------------------------------------------------------
module tb_glyph_run_extents_accumulator_top;
  import grex_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int RANDOM_ITEMS = 840;

  typedef logic signed [FIELD_BITS-1:0] coord_t;

  typedef struct {
    bit     is_first;
    bit     is_last;
    coord_t ink_left;
    coord_t ink_top;
    coord_t ink_span_x;
    coord_t ink_span_y;
    coord_t logic_top;
    coord_t logic_span_y;
    coord_t advance;
    coord_t offset_x;
    coord_t offset_y;
  } glyph_t;

  typedef struct {
    coord_t ink_x;
    coord_t ink_y;
    coord_t ink_w;
    coord_t ink_h;
    coord_t line_y;
    coord_t line_w;
    coord_t line_h;
  } extents_t;

  logic   clk;
  logic   rst;
  logic   in_valid;
  logic   in_stall;
  logic   first_glyph;
  logic   last_glyph;
  coord_t ink_left;
  coord_t ink_top;
  coord_t ink_span_x;
  coord_t ink_span_y;
  coord_t logic_top;
  coord_t logic_span_y;
  coord_t advance;
  coord_t offset_x;
  coord_t offset_y;
  logic   out_valid;
  logic   out_stall;
  coord_t run_ink_x;
  coord_t run_ink_y;
  coord_t run_ink_width;
  coord_t run_ink_height;
  coord_t run_logical_y;
  coord_t run_logical_width;
  coord_t run_logical_height;

  glyph_run_extents_accumulator_top i_dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .first_glyph        (first_glyph),
    .last_glyph         (last_glyph),
    .ink_left           (ink_left),
    .ink_top            (ink_top),
    .ink_span_x         (ink_span_x),
    .ink_span_y         (ink_span_y),
    .logic_top          (logic_top),
    .logic_span_y       (logic_span_y),
    .advance            (advance),
    .offset_x           (offset_x),
    .offset_y           (offset_y),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .run_ink_x          (run_ink_x),
    .run_ink_y          (run_ink_y),
    .run_ink_width      (run_ink_width),
    .run_ink_height     (run_ink_height),
    .run_logical_y      (run_logical_y),
    .run_logical_width  (run_logical_width),
    .run_logical_height (run_logical_height)
  );

  // Running extents, mirrored from the block
  coord_t pen_pos;
  coord_t box_x, box_y, box_w, box_h;
  coord_t line_y, line_w, line_h;

  extents_t pending_extents[$];
  int       error_count = 0;
  int       glyphs_sent = 0;
  int       cycle_count = 0;

  // Sender and receiver pacing
  int burst_left = 0;
  bit sender_bursty = 1'b1;
  bit hold_req = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic accumulate_glyph(input glyph_t g, output bit emits, output extents_t r);
    coord_t left, top, nx, ny, far_a, far_b;
    if (g.is_first) begin
      pen_pos = '0;
      box_x = '0; box_y = '0; box_w = '0; box_h = '0;
      line_y = '0; line_w = '0; line_h = '0;
    end
    if (g.ink_span_x != 0 && g.ink_span_y != 0) begin
      left = pen_pos + g.ink_left + g.offset_x;
      top  = g.ink_top + g.offset_y;
      if (box_w == 0 || box_h == 0) begin
        // empty box is replaced, not extended
        box_x = left;
        box_y = top;
        box_w = g.ink_span_x;
        box_h = g.ink_span_y;
      end else begin
        nx = (left < box_x) ? left : box_x;
        ny = (top < box_y) ? top : box_y;
        far_a = box_x + box_w;
        far_b = left + g.ink_span_x;
        box_w = ((far_a < far_b) ? far_b : far_a) - nx;
        far_a = box_y + box_h;
        far_b = top + g.ink_span_y;
        box_h = ((far_a < far_b) ? far_b : far_a) - ny;
        box_x = nx;
        box_y = ny;
      end
    end
    line_w = line_w + g.advance;
    if (g.is_first) begin
      line_y = g.logic_top;
      line_h = g.logic_span_y;
    end else begin
      ny = (g.logic_top < line_y) ? g.logic_top : line_y;
      far_a = line_y + line_h;
      far_b = g.logic_top + g.logic_span_y;
      line_h = ((far_a < far_b) ? far_b : far_a) - ny;
      line_y = ny;
    end
    pen_pos = pen_pos + g.advance;
    emits = g.is_last;
    r = '{box_x, box_y, box_w, box_h, line_y, line_w, line_h};
  endtask

  task automatic check_field(input string label, input coord_t want, input coord_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch: expected %0d, got %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  // Result checker and request predictor
  always @(posedge clk) begin : monitor
    extents_t want;
    extents_t predicted;
    glyph_t   g;
    bit       emits;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (pending_extents.size() == 0) begin
          $display("%0t ns: result with none expected: expected nothing, got ink %0d,%0d",
                   $time, run_ink_x, run_ink_y);
          error_count++;
        end else begin
          want = pending_extents.pop_front();
          check_field("run_ink_x", want.ink_x, run_ink_x);
          check_field("run_ink_y", want.ink_y, run_ink_y);
          check_field("run_ink_width", want.ink_w, run_ink_width);
          check_field("run_ink_height", want.ink_h, run_ink_height);
          check_field("run_logical_y", want.line_y, run_logical_y);
          check_field("run_logical_width", want.line_w, run_logical_width);
          check_field("run_logical_height", want.line_h, run_logical_height);
        end
      end
      if (in_valid && !in_stall) begin
        g = '{first_glyph, last_glyph, ink_left, ink_top, ink_span_x, ink_span_y,
              logic_top, logic_span_y, advance, offset_x, offset_y};
        accumulate_glyph(g, emits, predicted);
        if (emits) pending_extents.push_back(predicted);
      end
    end
  end

  // Receiver: changing stall patterns plus a long hold-off when hold_req is set
  initial begin : receiver
    int hold_left;
    int mode_left;
    int stall_mode;
    int phase;
    hold_left = 0;
    mode_left = 0;
    stall_mode = 0;
    phase = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_left = HOLD_OFF_CYCLES;
        hold_req = 1'b0;
      end
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 200);
      end
      mode_left--;
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= (phase % 5 >= 3);
          default: out_stall <= ($urandom_range(0, 9) < 7);
        endcase
      end
    end
  end

  task automatic send_glyph(input glyph_t g);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_bursty ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    first_glyph  <= g.is_first;
    last_glyph   <= g.is_last;
    ink_left     <= g.ink_left;
    ink_top      <= g.ink_top;
    ink_span_x   <= g.ink_span_x;
    ink_span_y   <= g.ink_span_y;
    logic_top    <= g.logic_top;
    logic_span_y <= g.logic_span_y;
    advance      <= g.advance;
    offset_x     <= g.offset_x;
    offset_y     <= g.offset_y;
    do @(posedge clk); while (in_stall);
    glyphs_sent++;
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0, 1: return $urandom;
      2: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return '0;
          3: return -1;
          default: return 1;
        endcase
      end
      default: return $signed($urandom_range(0, 4000)) - 2000;
    endcase
  endfunction

  function automatic coord_t rand_span();
    if ($urandom_range(0, 4) == 0) return '0;
    return rand_coord();
  endfunction

  function automatic glyph_t rand_glyph(input bit f, input bit l);
    glyph_t g;
    g.is_first     = f;
    g.is_last      = l;
    g.ink_left     = rand_coord();
    g.ink_top      = rand_coord();
    g.ink_span_x   = rand_span();
    g.ink_span_y   = rand_span();
    g.logic_top    = rand_coord();
    g.logic_span_y = rand_coord();
    g.advance      = rand_coord();
    g.offset_x     = rand_coord();
    g.offset_y     = rand_coord();
    return g;
  endfunction

  function automatic glyph_t flat_glyph(input bit f, input bit l, input coord_t v);
    return '{f, l, v, v, v, v, v, v, v, v, v};
  endfunction

  // Must run right after reset: glyphs with no first mark start from zero state
  task automatic test_no_first_mark();
    send_glyph('{1'b0, 1'b0, 10, -20, 5, 7, -30, 40, 12, 1, 2});
    send_glyph('{1'b0, 1'b1, -4, 3, 8, 2, -10, 50, 9, -1, 6});
    // continues after a last glyph
    send_glyph('{1'b0, 1'b1, 2, 2, 3, 3, 100, 5, -7, 0, 0});
  endtask

  task automatic test_empty_ink();
    send_glyph('{1'b1, 1'b0, 7, 7, 0, 5, -12, 20, 30, 0, 0});
    send_glyph('{1'b0, 1'b0, 7, 7, 9, 0, -15, 10, 30, 0, 0});
    send_glyph('{1'b0, 1'b1, 3, -8, 4, 6, -5, 30, 10, 2, -1});
    send_glyph('{1'b1, 1'b1, 1, 1, 0, 0, 4, 4, 4, 4, 4});
    // negative spans, used as they come
    send_glyph('{1'b1, 1'b0, 5, 5, -10, -3, 0, -8, 20, 0, 0});
    send_glyph('{1'b0, 1'b1, -2, 4, 6, 9, 3, -6, -25, 1, 1});
  endtask

  task automatic test_field_extremes();
    send_glyph(flat_glyph(1'b1, 1'b1, 32'sh7FFF_FFFF));
    send_glyph(flat_glyph(1'b1, 1'b1, 32'sh8000_0000));
    send_glyph(flat_glyph(1'b1, 1'b1, -1));
    send_glyph(flat_glyph(1'b1, 1'b1, '0));
    // wrap across the sign boundary inside one run
    send_glyph(flat_glyph(1'b1, 1'b0, 32'sh7FFF_FFFF));
    send_glyph(flat_glyph(1'b0, 1'b0, 32'sh8000_0000));
    send_glyph(flat_glyph(1'b0, 1'b1, 32'sh7FFF_FFF0));
  endtask

  task automatic test_receiver_hold_off();
    sender_bursty = 1'b0;
    hold_req = 1'b1;
    repeat (40) send_glyph(rand_glyph(1'b1, 1'b1));
    sender_bursty = 1'b1;
  endtask

  task automatic test_random_runs();
    int run_len;
    int target;
    target = glyphs_sent + RANDOM_ITEMS;
    while (glyphs_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        // noise: marks at random
        send_glyph(rand_glyph(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1))));
      end else begin
        run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++)
          send_glyph(rand_glyph(i == 0, i == run_len - 1));
      end
    end
  endtask

  initial begin
    rst          = 1'b1;
    in_valid     = 1'b0;
    first_glyph  = 1'b0;
    last_glyph   = 1'b0;
    ink_left     = '0;
    ink_top      = '0;
    ink_span_x   = '0;
    ink_span_y   = '0;
    logic_top    = '0;
    logic_span_y = '0;
    advance      = '0;
    offset_x     = '0;
    offset_y     = '0;
    pen_pos = '0;
    box_x = '0; box_y = '0; box_w = '0; box_h = '0;
    line_y = '0; line_w = '0; line_h = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    test_no_first_mark();
    test_empty_ink();
    test_field_extremes();
    test_receiver_hold_off();
    test_random_runs();

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_extents.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
